>>> sv/assert_macros.svh
// Assertion macros shared by the rational arithmetic block.
// Included by modules that check their own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> sv/rar_pkg.sv
// Types and command codes for the rational arithmetic block.
// Used by the front end, the reduction unit and the top level.
package rar_pkg;
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_INC = 3'd3;
  localparam logic [2:0] CMD_DEC = 3'd4;
  localparam logic [2:0] CMD_RED = 3'd5;
  localparam int MAG_W = 65;
  typedef struct packed {
    logic          num_neg;
    logic          den_neg;
    logic          err;
    logic [MAG_W-1:0] num_mag;
    logic [MAG_W-1:0] den_mag;
  } job_t;
endpackage

>>> sv/rar_front.sv
// Front end: classifies the command, forms products and sums in sign/magnitude.
// Depends on rar_pkg. Runs a short sequence per item and hands a job_t on.
module rar_front import rar_pkg::*; #(
  parameter int OW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    cmd,
  input  logic [OW-1:0] ln,
  input  logic [OW-1:0] ld,
  input  logic [OW-1:0] rn,
  input  logic [OW-1:0] rd,
  output logic          job_valid,
  input  logic          job_ready,
  output job_t          job
);
  localparam int PW = 2 * OW;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_SUM = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;
  logic [1:0] st_r, st_nxt;
  logic [2:0] cmd_r;
  logic [OW-1:0] lnm_r, ldm_r, rnm_r, rdm_r;
  logic lns_r, lds_r, rns_r, rds_r, err_r;
  logic [PW-1:0] p0_r, p1_r, p2_r;
  logic s0_r, s1_r, s2_r;
  job_t job_r;

  function automatic logic [OW-1:0] mag(input logic [OW-1:0] x);
    mag = x[OW-1] ? (~x + 1'b1) : x;
  endfunction

  logic bin;
  assign bin = (cmd_r == CMD_ADD) || (cmd_r == CMD_SUB) || (cmd_r == CMD_MUL);
  assign in_ready = (st_r == S_IDLE);
  assign job_valid = (st_r == S_OUT);
  assign job = job_r;

  logic [PW:0] am, bm, sm;
  logic as, bs, ss;
  always_comb begin
    am = {1'b0, p0_r};
    as = s0_r;
    bm = {1'b0, p1_r};
    bs = s1_r;
    if (cmd_r == CMD_SUB) bs = !s1_r;
    if (as == bs) begin
      sm = am + bm;
      ss = as;
    end else if (am >= bm) begin
      sm = am - bm;
      ss = as;
    end else begin
      sm = bm - am;
      ss = bs;
    end
    if (sm == '0) ss = 1'b0;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_MUL;
      S_MUL: st_nxt = S_SUM;
      S_SUM: st_nxt = S_OUT;
      S_OUT: if (job_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    case (st_r)
      S_IDLE: begin
        cmd_r <= cmd;
        lnm_r <= mag(ln); lns_r <= ln[OW-1];
        ldm_r <= mag(ld); lds_r <= ld[OW-1];
        rnm_r <= mag(rn); rns_r <= rn[OW-1];
        rdm_r <= mag(rd); rds_r <= rd[OW-1];
      end
      S_MUL: begin
        err_r <= (ldm_r == '0) || (bin && rdm_r == '0);
        case (cmd_r)
          CMD_ADD, CMD_SUB: begin
            p0_r <= PW'(lnm_r) * PW'(rdm_r); s0_r <= lns_r ^ rds_r;
            p1_r <= PW'(rnm_r) * PW'(ldm_r); s1_r <= rns_r ^ lds_r;
          end
          CMD_MUL: begin
            p0_r <= PW'(lnm_r) * PW'(rnm_r); s0_r <= lns_r ^ rns_r;
            p1_r <= '0; s1_r <= 1'b0;
          end
          CMD_INC: begin
            p0_r <= PW'(lnm_r); s0_r <= lns_r;
            p1_r <= PW'(ldm_r); s1_r <= lds_r;
          end
          CMD_DEC: begin
            p0_r <= PW'(lnm_r); s0_r <= lns_r;
            p1_r <= PW'(ldm_r); s1_r <= !lds_r;
          end
          default: begin
            p0_r <= PW'(lnm_r); s0_r <= lns_r;
            p1_r <= '0; s1_r <= 1'b0;
          end
        endcase
        if (bin) begin
          p2_r <= PW'(ldm_r) * PW'(rdm_r); s2_r <= lds_r ^ rds_r;
        end else begin
          p2_r <= PW'(ldm_r); s2_r <= lds_r;
        end
      end
      S_SUM: begin
        job_r.err <= err_r;
        job_r.num_mag <= MAG_W'(sm);
        job_r.num_neg <= ss && (sm != '0);
        job_r.den_mag <= MAG_W'(p2_r);
        job_r.den_neg <= s2_r && (p2_r != '0);
      end
      default: ;
    endcase
  end
endmodule

>>> sv/rar_fifo.sv
// Two-entry queue of job_t between the front end and the reduction unit.
// Depends on rar_pkg.
module rar_fifo import rar_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  `include "assert_macros.svh"
  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
  `ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3)
  `ASSERT_IMPL(a_ptr_full, clk, rst_n, cnt_r == 2'd2 || cnt_r == 2'd0, wp_r == rp_r)
  `ASSERT_IMPL(a_ptr_one, clk, rst_n, cnt_r == 2'd1, wp_r != rp_r)
endmodule

>>> sv/rar_reduce.sv
// Reduction unit: binary GCD of the magnitudes, then two restoring divisions.
// Depends on rar_pkg. Holds the result in an output register.
module rar_reduce import rar_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [32:0]       out_num,
  output logic [31:0]       out_den,
  output logic              out_err
);
  `include "assert_macros.svh"
  localparam int CW = $clog2(MAG_W + 1);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD = 3'd1;
  localparam logic [2:0] S_DIVN = 3'd2;
  localparam logic [2:0] S_DIVD = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;
  logic [2:0] st_r;
  job_t j_r;
  logic [MAG_W-1:0] a_r, b_r, g_r, q_r, rem_r;
  logic [CW-1:0] k_r, bit_r;
  logic [MAG_W-1:0] qn_r;
  logic [32:0] onum_r;
  logic [31:0] oden_r;
  logic oerr_r;

  assign job_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_num = onum_r;
  assign out_den = oden_r;
  assign out_err = oerr_r;

  logic [MAG_W:0] trial;
  assign trial = {rem_r, (st_r == S_DIVN) ? j_r.num_mag[bit_r[CW-1:0]]
                                          : j_r.den_mag[bit_r[CW-1:0]]} - {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (job_valid) begin
          j_r <= job;
          a_r <= job.num_mag;
          b_r <= job.den_mag;
          k_r <= '0;
          st_r <= job.err ? S_OUT : S_GCD;
          onum_r <= '0; oden_r <= '0; oerr_r <= job.err;
        end
        S_GCD: begin
          if (a_r == '0 || b_r == '0 || a_r == b_r) begin
            g_r <= ((a_r == '0) ? b_r : a_r) << k_r;
            rem_r <= '0; q_r <= '0;
            bit_r <= CW'(MAG_W - 1);
            st_r <= S_DIVN;
          end else if (!a_r[0] && !b_r[0]) begin
            a_r <= a_r >> 1; b_r <= b_r >> 1; k_r <= k_r + 1'b1;
          end else if (!a_r[0]) a_r <= a_r >> 1;
          else if (!b_r[0]) b_r <= b_r >> 1;
          else if (a_r > b_r) a_r <= (a_r - b_r) >> 1;
          else b_r <= (b_r - a_r) >> 1;
        end
        S_DIVN, S_DIVD: begin
          if (bit_r == '0) begin
            rem_r <= '0;
            bit_r <= CW'(MAG_W - 1);
            if (st_r == S_DIVN) begin
              qn_r <= {q_r[MAG_W-2:0], !trial[MAG_W]};
              q_r <= '0;
              st_r <= S_DIVD;
            end else begin
              onum_r <= j_r.num_neg ? 33'(~qn_r + 1'b1) : qn_r[32:0];
              oden_r <= j_r.den_neg ? 32'(~{q_r[MAG_W-2:0], !trial[MAG_W]} + 1'b1)
                                    : 32'({q_r[MAG_W-2:0], !trial[MAG_W]});
              st_r <= S_OUT;
            end
          end else begin
            if (!trial[MAG_W]) rem_r <= trial[MAG_W-1:0];
            else rem_r <= {rem_r[MAG_W-2:0], (st_r == S_DIVN) ?
                           j_r.num_mag[bit_r] : j_r.den_mag[bit_r]};
            q_r <= {q_r[MAG_W-2:0], !trial[MAG_W]};
            bit_r <= bit_r - 1'b1;
          end
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(onum_r))
  `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && out_err, onum_r == '0 && oden_r == '0)
  `ASSERT_IMPL(a_gcd_nz, clk, rst_n, st_r == S_DIVN, g_r != '0)
endmodule

>>> sv/rational_arith_reduce.sv
// Rational arithmetic with GCD reduction on signed fractions.
// Each item passes through the front end and the queue, is loaded into the reducer, and
// then runs binary GCD steps and two restoring divisions before its result is presented.
// A zero denominator skips the reduction and goes from the load straight to the output.
// The single reduction unit sets the rate; the front end can work ahead while the queue has room.
// Synchronous active-low reset clears the state registers and queue pointers; the queue empties.
module rational_arith_reduce import rar_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [4*OPERAND_WIDTH+7:0] in_tdata,  // cmd, left_num, left_den, right_num, right_den, pad
  output logic out_tvalid,
  input  logic out_tready,
  output logic [71:0] out_tdata  // result_num, result_den, zero_den_error, pad
);
  localparam int OW = OPERAND_WIDTH;
  job_t fj, qj;
  logic fv, fr, qv, qr;
  logic [32:0] rn;
  logic [31:0] rdn;
  logic re;
  rar_front #(.OW(OW)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .cmd(in_tdata[2:0]),
    .ln(in_tdata[3+OW-1:3]), .ld(in_tdata[3+2*OW-1:3+OW]),
    .rn(in_tdata[3+3*OW-1:3+2*OW]), .rd(in_tdata[3+4*OW-1:3+3*OW]),
    .job_valid(fv), .job_ready(fr), .job(fj));
  rar_fifo u_fifo (.clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qj));
  rar_reduce u_red (.clk, .rst_n, .job_valid(qv), .job_ready(qr), .job(qj),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_num(rn), .out_den(rdn), .out_err(re));
  assign out_tdata = {6'd0, re, rdn, rn};
endmodule
